>>> rtl/gfba_pkg.sv
// Shared types and codes for the grouped free block allocator.
package gfba_pkg;

    localparam int unsigned BLOCK_W = 24;

    typedef enum logic [1:0] {
        REQ_ALLOC  = 2'd0,
        REQ_FREE   = 2'd1,
        REQ_REFILL = 2'd2,
        REQ_SPILL  = 2'd3
    } req_type_t;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_NO_SPACE      = 3'd1,
        ST_REFILL_NEEDED = 3'd2,
        ST_SPILL_NEEDED  = 3'd3,
        ST_WORD_TAKEN    = 3'd4,
        ST_SPILL_DATA    = 3'd5,
        ST_BAD_REQUEST   = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_REFILL = 2'd1,
        MODE_SPILL  = 2'd2
    } mode_t;

    typedef enum logic {
        ENG_IDLE = 1'b0,
        ENG_READ = 1'b1
    } eng_state_t;

    typedef struct packed {
        req_type_t            req_type;
        logic [BLOCK_W-1:0]   block_number;
        logic [BLOCK_W-1:0]   data_word;
    } req_t;

    typedef struct packed {
        status_t              status;
        logic [BLOCK_W-1:0]   block_out;
        logic [BLOCK_W-1:0]   spill_value;
        logic                 last_word;
        logic                 modified;
    } rsp_t;

endpackage

>>> rtl/gfba_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
module gfba_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 100
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/grouped_free_block_allocator.sv
// Grouped free block allocator: top level with free stack control.
//
// Usage:
//   req channel (req_valid/req_stall/req) carries one request word: allocate,
//   free a block, a refill word in, or a request for the next spill word out.
//   rsp channel (rsp_valid/rsp_stall/rsp) returns exactly one response word
//   per request, in order.
// Flow: free, refill words, the first spill word (the count) and rejected
//   requests issue back to back while the output register is not stalled.
//   allocate (non-empty stack) and spill entry words stall the next request
//   for an entry read: the free stack sits in a RAM with a registered read
//   port, so the popped or streamed entry is available the cycle after the
//   request is taken.
//   Response appears in the output register the cycle after it is formed.
// Reset: count, mode, stream index and modified flag clear; the stack RAM
//   is not cleared, entries are only read after being written.
// Stalls: the response is held in the output register while rsp_stall is
//   high; req_stall rises while that register is full and stalled, or while
//   an entry read is outstanding.
module grouped_free_block_allocator #(
    parameter int unsigned STACK_DEPTH = 100
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  gfba_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output gfba_pkg::rsp_t rsp
);

    localparam int unsigned AW = $clog2(STACK_DEPTH);
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned BW = gfba_pkg::BLOCK_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

    // control state
    gfba_pkg::eng_state_t eng_state_reg, eng_state_next;
    gfba_pkg::mode_t      mode_reg, mode_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        index_reg, index_next;
    logic                 dirty_reg, dirty_next;
    // entry 0 holds the planted end marker, not yet written to the RAM
    logic                 zero_bottom_reg, zero_bottom_next;
    logic                 out_valid_reg, out_valid_next;

    // payload state
    logic [BW-1:0]        pending_reg, pending_next;
    logic [AW-1:0]        rd_addr_reg, rd_addr_next;
    logic                 rd_spill_reg, rd_spill_next;
    logic                 rd_last_reg, rd_last_next;
    gfba_pkg::rsp_t       out_reg, out_next;

    // RAM ports
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [BW-1:0]        wr_data;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [BW-1:0]        rd_data;

    logic                 out_free;
    logic                 accept;
    logic                 rsp_load;
    gfba_pkg::rsp_t       rsp_word;
    logic [CW-1:0]        count_m1;
    logic [CW-1:0]        index_m1;
    logic [BW-1:0]        entry;
    logic [CW-1:0]        refill_count;

    gfba_ram #(
        .WIDTH (BW),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free  = !out_valid_reg || !rsp_stall;
    assign req_stall = (eng_state_reg != gfba_pkg::ENG_IDLE) || !out_free;
    assign accept    = req_valid && !req_stall;
    assign count_m1  = count_reg - 1'b1;
    assign index_m1  = index_reg - 1'b1;
    // planted marker reads as 0 until entry 0 is really written
    assign entry     = (zero_bottom_reg && rd_addr_reg == '0) ? '0 : rd_data;
    assign refill_count = (req.data_word > BW'(STACK_DEPTH)) ? DEPTH_C
                                                             : req.data_word[CW-1:0];

    always_comb
    begin
        eng_state_next   = eng_state_reg;
        mode_next        = mode_reg;
        count_next       = count_reg;
        index_next       = index_reg;
        dirty_next       = dirty_reg;
        zero_bottom_next = zero_bottom_reg;
        pending_next     = pending_reg;
        rd_addr_next     = rd_addr_reg;
        rd_spill_next    = rd_spill_reg;
        rd_last_next     = rd_last_reg;
        wr_en            = 1'b0;
        wr_addr          = '0;
        wr_data          = '0;
        rd_en            = 1'b0;
        rd_addr          = '0;
        rsp_load         = 1'b0;
        rsp_word         = '0;
        rsp_word.status  = gfba_pkg::ST_BAD_REQUEST;
        rsp_word.modified = dirty_reg;

        case (eng_state_reg)
            gfba_pkg::ENG_IDLE:
            begin
                if (accept)
                begin
                    case (mode_reg)
                        gfba_pkg::MODE_IDLE:
                        begin
                            if (req.req_type == gfba_pkg::REQ_ALLOC)
                            begin
                                if (count_reg == '0)
                                begin
                                    rsp_word.status = gfba_pkg::ST_NO_SPACE;
                                    rsp_load        = 1'b1;
                                end
                                else
                                begin
                                    // pop now, judge the entry once it is read back
                                    count_next     = count_m1;
                                    rd_en          = 1'b1;
                                    rd_addr        = count_m1[AW-1:0];
                                    rd_addr_next   = count_m1[AW-1:0];
                                    rd_spill_next  = 1'b0;
                                    rd_last_next   = 1'b0;
                                    eng_state_next = gfba_pkg::ENG_READ;
                                end
                            end
                            else if (req.req_type == gfba_pkg::REQ_FREE)
                            begin
                                dirty_next        = 1'b1;
                                rsp_word.modified = 1'b1;
                                rsp_word.status   = gfba_pkg::ST_OK;
                                rsp_load          = 1'b1;
                                if (count_reg == '0)
                                begin
                                    // marker at entry 0, block at entry 1
                                    zero_bottom_next = 1'b1;
                                    wr_en            = 1'b1;
                                    wr_addr          = AW'(1);
                                    wr_data          = req.block_number;
                                    count_next       = CW'(2);
                                end
                                else if (count_reg >= DEPTH_C)
                                begin
                                    rsp_word.status    = gfba_pkg::ST_SPILL_NEEDED;
                                    rsp_word.block_out = req.block_number;
                                    mode_next          = gfba_pkg::MODE_SPILL;
                                    index_next         = '0;
                                    pending_next       = req.block_number;
                                end
                                else
                                begin
                                    wr_en      = 1'b1;
                                    wr_addr    = count_reg[AW-1:0];
                                    wr_data    = req.block_number;
                                    count_next = count_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                rsp_load = 1'b1;
                            end
                        end

                        gfba_pkg::MODE_REFILL:
                        begin
                            rsp_load = 1'b1;
                            if (req.req_type == gfba_pkg::REQ_REFILL)
                            begin
                                rsp_word.status    = gfba_pkg::ST_WORD_TAKEN;
                                rsp_word.block_out = pending_reg;
                                if (index_reg == '0)
                                begin
                                    count_next = refill_count;
                                end
                                else
                                begin
                                    wr_en   = 1'b1;
                                    wr_addr = index_m1[AW-1:0];
                                    wr_data = req.data_word;
                                    if (index_m1 == '0)
                                    begin
                                        zero_bottom_next = 1'b0;
                                    end
                                end
                                if (index_reg == DEPTH_C)
                                begin
                                    rsp_word.last_word = 1'b1;
                                    mode_next          = gfba_pkg::MODE_IDLE;
                                    index_next         = '0;
                                end
                                else
                                begin
                                    index_next = index_reg + 1'b1;
                                end
                            end
                        end

                        gfba_pkg::MODE_SPILL:
                        begin
                            if (req.req_type == gfba_pkg::REQ_SPILL)
                            begin
                                if (index_reg == '0)
                                begin
                                    // count word first, never the last one
                                    rsp_word.status      = gfba_pkg::ST_SPILL_DATA;
                                    rsp_word.block_out   = pending_reg;
                                    rsp_word.spill_value = BW'(count_reg);
                                    rsp_load             = 1'b1;
                                    index_next           = index_reg + 1'b1;
                                end
                                else
                                begin
                                    rd_en          = 1'b1;
                                    rd_addr        = index_m1[AW-1:0];
                                    rd_addr_next   = index_m1[AW-1:0];
                                    rd_spill_next  = 1'b1;
                                    rd_last_next   = (index_reg == DEPTH_C);
                                    eng_state_next = gfba_pkg::ENG_READ;
                                    if (index_reg == DEPTH_C)
                                    begin
                                        // last read is the top entry, not entry 0
                                        wr_en            = 1'b1;
                                        wr_addr          = '0;
                                        wr_data          = pending_reg;
                                        zero_bottom_next = 1'b0;
                                        count_next       = CW'(1);
                                        mode_next        = gfba_pkg::MODE_IDLE;
                                        index_next       = '0;
                                    end
                                    else
                                    begin
                                        index_next = index_reg + 1'b1;
                                    end
                                end
                            end
                            else
                            begin
                                rsp_load = 1'b1;
                            end
                        end

                        default:
                        begin
                            rsp_load = 1'b1;
                        end
                    endcase
                end
            end

            gfba_pkg::ENG_READ:
            begin
                if (out_free)
                begin
                    rsp_load       = 1'b1;
                    eng_state_next = gfba_pkg::ENG_IDLE;
                    if (rd_spill_reg)
                    begin
                        rsp_word.status      = gfba_pkg::ST_SPILL_DATA;
                        rsp_word.block_out   = pending_reg;
                        rsp_word.spill_value = entry;
                        rsp_word.last_word   = rd_last_reg;
                    end
                    else if (entry == '0)
                    begin
                        // end marker: list exhausted
                        count_next      = '0;
                        rsp_word.status = gfba_pkg::ST_NO_SPACE;
                    end
                    else
                    begin
                        dirty_next         = 1'b1;
                        rsp_word.modified  = 1'b1;
                        rsp_word.block_out = entry;
                        if (count_reg == '0)
                        begin
                            rsp_word.status = gfba_pkg::ST_REFILL_NEEDED;
                            mode_next       = gfba_pkg::MODE_REFILL;
                            index_next      = '0;
                            pending_next    = entry;
                        end
                        else
                        begin
                            rsp_word.status = gfba_pkg::ST_OK;
                        end
                    end
                end
            end

            default:
            begin
                eng_state_next = gfba_pkg::ENG_IDLE;
            end
        endcase

        if (rsp_load)
        begin
            out_valid_next = 1'b1;
            out_next       = rsp_word;
        end
        else
        begin
            out_valid_next = out_valid_reg && rsp_stall;
            out_next       = out_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eng_state_reg   <= gfba_pkg::ENG_IDLE;
            mode_reg        <= gfba_pkg::MODE_IDLE;
            count_reg       <= '0;
            index_reg       <= '0;
            dirty_reg       <= 1'b0;
            zero_bottom_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            pending_reg     <= '0;
        end
        else
        begin
            eng_state_reg   <= eng_state_next;
            mode_reg        <= mode_next;
            count_reg       <= count_next;
            index_reg       <= index_next;
            dirty_reg       <= dirty_next;
            zero_bottom_reg <= zero_bottom_next;
            out_valid_reg   <= out_valid_next;
            pending_reg     <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg  <= rd_addr_next;
        rd_spill_reg <= rd_spill_next;
        rd_last_reg  <= rd_last_next;
        out_reg      <= out_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

>>> sim/gfba_checker.sv
// Free list predictor and response checker for the grouped free block allocator.
module gfba_checker
    import gfba_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = 100
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_stall,
    input  req_t req,
    input  logic rsp_valid,
    input  logic rsp_stall,
    input  rsp_t rsp,
    output int   fail_count,
    output int   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned AW = $clog2(STACK_DEPTH);

    // predicted free list
    logic [BLOCK_W-1:0] blocks [STACK_DEPTH];
    int unsigned        n_free;
    mode_t              cur_mode;
    int unsigned        word_pos;
    logic [BLOCK_W-1:0] group_blk;
    logic               dirty;

    rsp_t owed_rsp [$];
    rsp_t want;
    int   mismatches;

    // advance the predicted free list by one request word
    task automatic step_free_list(input req_t w, output rsp_t r);
        logic [BLOCK_W-1:0] got;
        r = '0;
        r.status = ST_BAD_REQUEST;
        if (cur_mode == MODE_IDLE && w.req_type == REQ_ALLOC)
        begin
            if (n_free == 0 || n_free > STACK_DEPTH)
            begin
                n_free = 0;
                r.status = ST_NO_SPACE;
            end
            else
            begin
                n_free--;
                got = blocks[AW'(n_free)];
                if (got == '0)
                begin
                    // end marker: list exhausted
                    n_free = 0;
                    r.status = ST_NO_SPACE;
                end
                else
                begin
                    dirty = 1'b1;
                    r.block_out = got;
                    if (n_free == 0)
                    begin
                        r.status = ST_REFILL_NEEDED;
                        cur_mode = MODE_REFILL;
                        word_pos = 0;
                        group_blk = got;
                    end
                    else
                        r.status = ST_OK;
                end
            end
        end
        else if (cur_mode == MODE_IDLE && w.req_type == REQ_FREE)
        begin
            dirty = 1'b1;
            if (n_free == 0)
            begin
                blocks[0] = '0;
                n_free = 1;
            end
            if (n_free >= STACK_DEPTH)
            begin
                r.status = ST_SPILL_NEEDED;
                r.block_out = w.block_number;
                cur_mode = MODE_SPILL;
                word_pos = 0;
                group_blk = w.block_number;
            end
            else
            begin
                blocks[AW'(n_free)] = w.block_number;
                n_free++;
                r.status = ST_OK;
            end
        end
        else if (cur_mode == MODE_REFILL && w.req_type == REQ_REFILL)
        begin
            r.status = ST_WORD_TAKEN;
            r.block_out = group_blk;
            if (word_pos == 0)
                n_free = (32'(w.data_word) > STACK_DEPTH) ? STACK_DEPTH : 32'(w.data_word);
            else if (word_pos <= STACK_DEPTH)
                blocks[AW'(word_pos - 1)] = w.data_word;
            if (word_pos >= STACK_DEPTH)
            begin
                r.last_word = 1'b1;
                cur_mode = MODE_IDLE;
                word_pos = 0;
            end
            else
                word_pos++;
        end
        else if (cur_mode == MODE_SPILL && w.req_type == REQ_SPILL)
        begin
            r.status = ST_SPILL_DATA;
            r.block_out = group_blk;
            if (word_pos == 0)
                r.spill_value = BLOCK_W'(n_free);
            else if (word_pos <= STACK_DEPTH)
                r.spill_value = blocks[AW'(word_pos - 1)];
            if (word_pos >= STACK_DEPTH)
            begin
                // group written out: list restarts with the freed block
                r.last_word = 1'b1;
                blocks[0] = group_blk;
                n_free = 1;
                cur_mode = MODE_IDLE;
                word_pos = 0;
            end
            else
                word_pos++;
        end
        r.modified = dirty;
    endtask

    task automatic check_field(input string name, input logic [BLOCK_W-1:0] exp_v,
                               input logic [BLOCK_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (blocks[i])
                blocks[i] = '0;
            n_free = 0;
            cur_mode = MODE_IDLE;
            word_pos = 0;
            group_blk = '0;
            dirty = 1'b0;
            mismatches = 0;
            owed_rsp.delete();
            fail_count <= 0;
            outstanding <= 0;
        end
        else
        begin
            // responses trail their requests, so compare before predicting
            if (rsp_valid && !rsp_stall)
            begin
                if (owed_rsp.size() == 0)
                begin
                    $error("response word with none owed: status %0d, block_out %0h",
                           rsp.status, rsp.block_out);
                    mismatches++;
                end
                else
                begin
                    want = owed_rsp.pop_front();
                    check_field("status", BLOCK_W'(want.status), BLOCK_W'(rsp.status));
                    check_field("block_out", want.block_out, rsp.block_out);
                    check_field("spill_value", want.spill_value, rsp.spill_value);
                    check_field("last_word", BLOCK_W'(want.last_word),
                                BLOCK_W'(rsp.last_word));
                    check_field("modified", BLOCK_W'(want.modified),
                                BLOCK_W'(rsp.modified));
                end
            end
            if (req_valid && !req_stall)
            begin
                step_free_list(req, want);
                owed_rsp.push_back(want);
            end
            fail_count <= mismatches;
            outstanding <= owed_rsp.size();
        end
    end

endmodule

>>> sim/tb.sv
// Top-level testbench: stimulus, idling and verdict for the grouped free block allocator.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import gfba_pkg::*;

    localparam int unsigned DEPTH       = 100;
    localparam int unsigned BLK_MAX     = 2**BLOCK_W - 1;
    localparam int          ITEMS       = 750;
    localparam int          STALL_LIMIT = 2000;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    int fail_count;
    int outstanding;

    // idling rates, moved on as the run progresses
    int unsigned src_idle_pct  = 37;
    int unsigned snk_stall_pct = 66;
    int          words_sent    = 0;

    // group transfers requested by the block, as seen on the response side
    int   refill_calls = 0;
    int   spill_calls  = 0;
    // fill tide: frees dominate until a spill; drain tide: allocates dominate
    // until the list runs dry
    logic want_fill    = 1'b1;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    grouped_free_block_allocator #(
        .STACK_DEPTH(DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    gfba_checker #(
        .STACK_DEPTH(DEPTH)
    ) ledger (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Receiver side: random stall per cycle at the current rate. Runs of
    // several free cycles fall out of the dice at 37 %, and the last third
    // of the run never stalls.
    always @(posedge clk)
        rsp_stall <= ($urandom_range(99, 0) < snk_stall_pct);

    // Watch responses to steer the stimulus: a refill or spill request from
    // the block is answered with a full group stream once the pipe is empty.
    always @(posedge clk)
    begin
        if (rsp_valid && !rsp_stall)
        begin
            case (rsp.status)
                ST_REFILL_NEEDED: refill_calls <= refill_calls + 1;
                ST_SPILL_NEEDED:
                begin
                    spill_calls <= spill_calls + 1;
                    want_fill <= 1'b0;
                end
                ST_NO_SPACE: want_fill <= 1'b1;
                default: ;
            endcase
        end
    end

    // Idling schedule: sender 37 % / receiver 66 %, then swapped, then none.
    task automatic set_pressure();
        if (words_sent < ITEMS / 3)
        begin
            src_idle_pct = 37;
            snk_stall_pct = 66;
        end
        else if (words_sent < 2 * ITEMS / 3)
        begin
            src_idle_pct = 66;
            snk_stall_pct = 37;
        end
        else
        begin
            src_idle_pct = 0;
            snk_stall_pct = 0;
        end
    endtask

    // Present one request word and hold it until the block takes it. Valid
    // is only lowered on an idle cycle, so back-to-back words keep it high
    // without a second assignment in the same step.
    task automatic send_word(input req_t w);
        set_pressure();
        while ($urandom_range(99, 0) < src_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= w;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        words_sent++;
    endtask

    // Drop valid and wait until every owed response has come back.
    task automatic settle();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    function automatic req_t word_of(input req_type_t kind,
                                     input logic [BLOCK_W-1:0] blk,
                                     input logic [BLOCK_W-1:0] dat);
        req_t w;
        w.req_type = kind;
        w.block_number = blk;
        w.data_word = dat;
        return w;
    endfunction

    function automatic req_t rand_word(input req_type_t kind);
        return word_of(kind, BLOCK_W'($urandom_range(BLK_MAX, 0)),
                       BLOCK_W'($urandom_range(BLK_MAX, 0)));
    endfunction

    // a request type that the current stream does not accept
    function automatic req_type_t other_kind(input req_type_t proper);
        req_type_t k;
        k = req_type_t'($urandom_range(3, 0));
        if (k == proper)
            k = req_type_t'(k + 2'd1);
        return k;
    endfunction

    // Outside a stream: mostly frees or allocates by tide, a few stray
    // stream words, and block numbers pulled to the extremes now and then.
    function automatic req_t idle_word();
        req_t        w;
        int unsigned roll;
        roll = $urandom_range(99, 0);
        if (roll < 3)
            return rand_word($urandom_range(1, 0) ? REQ_REFILL : REQ_SPILL);
        w = rand_word((roll < (want_fill ? 85 : 22)) ? REQ_FREE : REQ_ALLOC);
        roll = $urandom_range(99, 0);
        if (roll < 4)
            w.block_number = '0;
        else if (roll < 7)
            w.block_number = '1;
        return w;
    endfunction

    // Count word of a refill group. Small counts chain refills quickly;
    // zero empties the list, oversize counts must saturate at the depth.
    function automatic logic [BLOCK_W-1:0] group_count();
        int unsigned roll;
        roll = $urandom_range(99, 0);
        if (roll < 40)
            return BLOCK_W'($urandom_range(8, 1));
        if (roll < 70)
            return BLOCK_W'($urandom_range(DEPTH, 1));
        if (roll < 80)
            return BLOCK_W'(DEPTH);
        if (roll < 90)
            return BLOCK_W'($urandom_range(BLK_MAX, DEPTH + 1));
        return '0;
    endfunction

    // Stream a group in: count word, then one word per stack entry, with
    // the odd out-of-place request mixed in (must be refused, not counted).
    task automatic feed_group();
        req_t w;
        int   k;
        for (k = 0; k <= DEPTH; k++)
        begin
            if ($urandom_range(99, 0) < 4)
                send_word(rand_word(other_kind(REQ_REFILL)));
            w = rand_word(REQ_REFILL);
            if (k == 0)
                w.data_word = group_count();
            else if ($urandom_range(99, 0) < 5)
                w.data_word = '0;
            send_word(w);
        end
    endtask

    // Pull a full group out word by word, again with stray requests.
    task automatic dump_group();
        int k;
        for (k = 0; k <= DEPTH; k++)
        begin
            if ($urandom_range(99, 0) < 4)
                send_word(rand_word(other_kind(REQ_SPILL)));
            send_word(rand_word(REQ_SPILL));
        end
    endtask

    // Short directed opening on a fresh list: empty allocate, stream words
    // while idle, the end marker planted by a first free, a freed zero block
    // popping as no space, ordinary pops down to the marker.
    task automatic opening_words();
        send_word(word_of(REQ_ALLOC, '1, '1));
        send_word(word_of(REQ_REFILL, '0, '1));
        send_word(word_of(REQ_SPILL, '1, '0));
        send_word(word_of(REQ_FREE, '1, '1));
        send_word(word_of(REQ_FREE, '0, '0));
        send_word(word_of(REQ_ALLOC, '0, '0));
        send_word(word_of(REQ_ALLOC, '1, '1));
        send_word(word_of(REQ_FREE, 24'h000001, 24'h555555));
        send_word(word_of(REQ_FREE, 24'h800000, 24'hAAAAAA));
        send_word(word_of(REQ_ALLOC, 24'h7FFFFF, 24'h000001));
        send_word(word_of(REQ_ALLOC, 24'h000000, 24'h800000));
        send_word(word_of(REQ_ALLOC, '1, '1));
        send_word(word_of(REQ_FREE, 24'h5A5A5A, 24'hA5A5A5));
        send_word(word_of(REQ_ALLOC, 24'hA5A5A5, 24'h5A5A5A));
    endtask

    initial
    begin : stimulus
        int refills_done;
        int spills_done;
        refills_done = 0;
        spills_done = 0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        opening_words();
        settle();

        // Bursts of idle-mode words; each time the block asks for a group
        // transfer, the whole stream is sent before anything else.
        while (words_sent < ITEMS)
        begin
            if (refill_calls > refills_done)
            begin
                feed_group();
                refills_done++;
            end
            else if (spill_calls > spills_done)
            begin
                dump_group();
                spills_done++;
            end
            else
            begin
                repeat ($urandom_range(8, 1))
                    send_word(idle_word());
            end
            settle();
        end

        // every response is in; run on idle before the verdict to catch misbehaviour
        repeat (20)
            @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: too long with no word moving on either channel ends the run.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
